// ===== src/hamming_secded_codec_core_defines.svh =====
// assertion macros used by the secded codec top level
`ifndef HAMMING_SECDED_CODEC_CORE_DEFINES_SVH
`define HAMMING_SECDED_CODEC_CORE_DEFINES_SVH

// same-cycle implication, sampled on clock, off while reset is high
`define HSC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off while reset is high
`define HSC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/hsc_pkg.sv =====
// package with sizes, codes, types and bit-mapping functions of the secded codec
`timescale 1ns / 1ps

package hsc_pkg;

   // code geometry
   localparam int CHECK_BITS = 6;
   localparam int DATA_BITS  = 1 << (CHECK_BITS - 1);
   localparam int CODE_BITS  = DATA_BITS + CHECK_BITS;

   // transaction field widths
   localparam int DATA_W   = 32;
   localparam int CODE_W   = 39;
   localparam int SYN_W    = 6;
   localparam int STATUS_W = 3;

   // command codes
   localparam logic CMD_ENCODE = 1'b0;
   localparam logic CMD_DECODE = 1'b1;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_CLEAN     = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_CORRECTED = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_DOUBLE    = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_PARITY    = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_RANGE     = 3'd4;

   // result transaction payload
   typedef struct packed {
      logic [CODE_W-1:0]   code_out;
      logic [DATA_W-1:0]   data_out;
      logic [SYN_W-1:0]    syndrome;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   // true for 1-based check positions
   function automatic logic is_pow2(input int p);
      return (p & (p - 1)) == 0;
   endfunction

   // xor of the 1-based positions of all set bits
   function automatic logic [CHECK_BITS-1:0] pos_xor(input logic [CODE_BITS-1:0] w);
      logic [CHECK_BITS-1:0] s;
      s = '0;
      for (int p = 1; p <= CODE_BITS; p++) begin
         if (w[p-1]) begin
            s = s ^ CHECK_BITS'(p);
         end
      end
      return s;
   endfunction

   // place data bits at the non-check positions
   function automatic logic [CODE_BITS-1:0] scatter_data(input logic [DATA_BITS-1:0] d);
      logic [CODE_BITS-1:0] w;
      int                   k;
      w = '0;
      k = 0;
      for (int p = 1; p <= CODE_BITS; p++) begin
         if (!is_pow2(p)) begin
            w[p-1] = d[k];
            k++;
         end
      end
      return w;
   endfunction

   // pull data bits back out of the non-check positions
   function automatic logic [DATA_BITS-1:0] gather_data(input logic [CODE_BITS-1:0] w);
      logic [DATA_BITS-1:0] d;
      int                   k;
      d = '0;
      k = 0;
      for (int p = 1; p <= CODE_BITS; p++) begin
         if (!is_pow2(p)) begin
            d[k] = w[p-1];
            k++;
         end
      end
      return d;
   endfunction

endpackage

// ===== src/hsc_req_if.sv =====
// request channel carrying command, data word and received codeword
`timescale 1ns / 1ps

interface hsc_req_if
   import hsc_pkg::*;
();
   logic              valid;
   logic              ready;
   logic              command;
   logic [DATA_W-1:0] data_in;
   logic [CODE_W-1:0] code_in;

   modport source (output valid, command, data_in, code_in, input ready);
   modport sink (input valid, command, data_in, code_in, output ready);
endinterface

// ===== src/hsc_rsp_if.sv =====
// response channel carrying codeword, data word, syndrome and status
`timescale 1ns / 1ps

interface hsc_rsp_if
   import hsc_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [CODE_W-1:0]   code_out;
   logic [DATA_W-1:0]   data_out;
   logic [SYN_W-1:0]    syndrome;
   logic [STATUS_W-1:0] status;

   modport source (output valid, code_out, data_out, syndrome, status, input ready);
   modport sink (input valid, code_out, data_out, syndrome, status, output ready);
endinterface

// ===== src/hsc_enc.sv =====
// secded encoder: data word to codeword with check bits and overall parity
`timescale 1ns / 1ps

module hsc_enc
   import hsc_pkg::*;
(
   input  logic [DATA_W-1:0] data_in,
   output rsp_type           result
);

   logic [CODE_BITS-1:0]  body_raw;
   logic [CHECK_BITS-1:0] checks;
   logic [CODE_BITS-1:0]  body;
   logic                  overall;

   // data bits into place, check bits from the position xor
   always_comb begin
      body_raw = scatter_data(data_in[DATA_BITS-1:0]);
      checks   = pos_xor(body_raw);
      body     = body_raw;
      for (int k = 0; k < CHECK_BITS; k++) begin
         body[(1 << k) - 1] = checks[k];
      end
      overall = ^body;
   end

   // only the codeword is meaningful on encode
   always_comb begin
      result          = '0;
      result.code_out = CODE_W'({overall, body});
   end

endmodule

// ===== src/hsc_dec.sv =====
// secded decoder: syndrome, single-error correction, status and data extraction
`timescale 1ns / 1ps

module hsc_dec
   import hsc_pkg::*;
(
   input  logic [CODE_W-1:0] code_in,
   output rsp_type           result
);

   logic [CODE_BITS-1:0]  body;
   logic                  mismatch;
   logic [CHECK_BITS-1:0] syn;
   logic                  in_range;
   logic [CODE_BITS-1:0]  flip;
   logic [STATUS_W-1:0]   status;

   // syndrome and overall parity check
   always_comb begin
      body     = code_in[CODE_BITS-1:0];
      mismatch = (^body) ^ code_in[CODE_BITS];
      syn      = pos_xor(body);
      in_range = syn <= CHECK_BITS'(CODE_BITS);
   end

   // one-hot flip mask, only for a correctable single error
   always_comb begin
      for (int p = 1; p <= CODE_BITS; p++) begin
         flip[p-1] = mismatch && (syn == CHECK_BITS'(p));
      end
   end

   // error classification
   always_comb begin
      if (syn == '0) begin
         status = mismatch ? STATUS_PARITY : STATUS_CLEAN;
      end else if (!mismatch) begin
         status = STATUS_DOUBLE;
      end else if (in_range) begin
         status = STATUS_CORRECTED;
      end else begin
         status = STATUS_RANGE;
      end
   end

   // codeword field stays zero on decode
   always_comb begin
      result          = '0;
      result.data_out = DATA_W'(gather_data(body ^ flip));
      result.syndrome = SYN_W'(syn);
      result.status   = status;
   end

endmodule

// ===== src/hamming_secded_codec_core.sv =====
// top level of the extended hamming secded codec: input stage, codec logic, result stage
//
//   channel | dir | handshake     | payload
//   --------+-----+---------------+----------------------------------------------
//   req     | in  | valid / ready | command, data_in, code_in
//   rsp     | out | valid / ready | code_out, data_out, syndrome, status
//
// one transaction per clock sustained while rsp is ready; req enters the input register,
// then the result register, and the two bound a single pass of xor trees
// both stages advance while the result stage is empty or rsp is taken; req is still
// accepted into an empty input stage while a finished result waits
// reset is synchronous, active high, and clears only the stage valid flags
`timescale 1ns / 1ps
`include "hamming_secded_codec_core_defines.svh"

module hamming_secded_codec_core
   import hsc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   hsc_req_if.sink   req,
   hsc_rsp_if.source rsp
);

   logic              in_valid_ff, in_valid_in;
   logic              in_cmd_ff;
   logic [DATA_W-1:0] in_data_ff;
   logic [CODE_W-1:0] in_code_ff;

   logic              out_valid_ff, out_valid_in;
   rsp_type           out_ff, out_in;

   logic              out_open;
   logic              in_advance;
   logic              req_fire;

   rsp_type           enc_result;
   rsp_type           dec_result;

   // stage flow control
   assign out_open   = !out_valid_ff || rsp.ready;
   assign in_advance = in_valid_ff && out_open;
   assign req.ready  = !in_valid_ff || out_open;
   assign req_fire   = req.valid && req.ready;

   // input stage
   always_comb begin
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (in_advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_cmd_ff  <= req.command;
         in_data_ff <= req.data_in;
         in_code_ff <= req.code_in;
      end
   end

   // codec logic
   hsc_enc u_enc (
      .data_in (in_data_ff),
      .result  (enc_result)
   );

   hsc_dec u_dec (
      .code_in (in_code_ff),
      .result  (dec_result)
   );

   // result select and result stage
   always_comb begin
      out_in       = (in_cmd_ff == CMD_ENCODE) ? enc_result : dec_result;
      out_valid_in = out_open ? in_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_advance) begin
         out_ff <= out_in;
      end
   end

   // response outputs
   assign rsp.valid    = out_valid_ff;
   assign rsp.code_out = out_ff.code_out;
   assign rsp.data_out = out_ff.data_out;
   assign rsp.syndrome = out_ff.syndrome;
   assign rsp.status   = out_ff.status;

   // checks
   `HSC_ASSERT_NOW(a_full_stalls_req, in_valid_ff && out_valid_ff && !rsp.ready, !req.ready, "req taken while both stages are full")
   `HSC_ASSERT_NEXT(a_advance_fills_out, in_advance, out_valid_ff, "advanced transaction lost from result stage")
   `HSC_ASSERT_NOW(a_decode_no_code, out_valid_ff && out_ff.status != STATUS_CLEAN, out_ff.code_out == '0, "decode result carries a codeword")
   `HSC_ASSERT_NOW(a_corrected_syn, out_valid_ff && out_ff.status == STATUS_CORRECTED, out_ff.syndrome != '0 && out_ff.syndrome <= SYN_W'(CODE_BITS), "correction with a syndrome outside the codeword")

endmodule

// ===== bench/tb_top.sv =====
// self-checking testbench for the extended hamming secded codec top level
`timescale 1ns / 1ps

module tb_top;
   import hsc_pkg::*;

   localparam int STALL_MAX     = 17;
   localparam int HOLD_CYCLES   = 300;
   localparam int WATCHDOG_MAX  = 2000;
   localparam int RANDOM_ITEMS  = 650;
   localparam int BURST_ITEMS   = 40;
   localparam int DRAIN_CYCLES  = 8;

   logic clock;
   logic reset;

   hsc_req_if req_ch ();
   hsc_rsp_if rsp_ch ();

   hamming_secded_codec_core u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   // expected results in acceptance order
   rsp_type expected_rsp_q[$];

   int  error_count;
   int  checked_count;
   int  encode_count;
   int  status_count[5];
   bit  req_idle_on;
   bit  rsp_idle_on;
   bit  rsp_hold_req;
   int  quiet_cycles;

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // xor of the 1-based positions of the set bits of a codeword body
   function automatic logic [CHECK_BITS-1:0] position_sum(input logic [CODE_BITS-1:0] body);
      logic [CHECK_BITS-1:0] acc;
      acc = '0;
      for (int p = 1; p <= CODE_BITS; p++) begin
         if (body[p-1]) begin
            acc ^= CHECK_BITS'(p);
         end
      end
      return acc;
   endfunction

   // expected result of one request transaction
   function automatic rsp_type codec_predict(input logic cmd, input logic [DATA_W-1:0] din,
                                             input logic [CODE_W-1:0] cin);
      rsp_type               res;
      logic [CODE_BITS-1:0]  body;
      logic [CHECK_BITS-1:0] syn;
      logic                  mismatch;
      int                    di;
      res = '0;
      di  = 0;
      if (cmd == CMD_ENCODE) begin
         // data bits into non power-of-two positions, then fill the check positions
         body = '0;
         for (int p = 1; p <= CODE_BITS; p++) begin
            if ((p & (p - 1)) != 0) begin
               body[p-1] = din[di];
               di++;
            end
         end
         syn = position_sum(body);
         for (int k = 0; k < CHECK_BITS; k++) begin
            body[(1 << k) - 1] = syn[k];
         end
         res.code_out = CODE_W'({^body, body});
      end else begin
         body     = cin[CODE_BITS-1:0];
         mismatch = ^cin[CODE_BITS:0];
         syn      = position_sum(body);
         if (syn == '0) begin
            res.status = mismatch ? STATUS_PARITY : STATUS_CLEAN;
         end else if (!mismatch) begin
            res.status = STATUS_DOUBLE;
         end else if (syn <= CODE_BITS) begin
            body[syn-1] = ~body[syn-1];
            res.status  = STATUS_CORRECTED;
         end else begin
            res.status = STATUS_RANGE;
         end
         res.syndrome = syn;
         for (int p = 1; p <= CODE_BITS; p++) begin
            if ((p & (p - 1)) != 0) begin
               res.data_out[di] = body[p-1];
               di++;
            end
         end
      end
      return res;
   endfunction

   // valid codeword for a data word
   function automatic logic [CODE_W-1:0] clean_code(input logic [DATA_W-1:0] din);
      rsp_type r;
      r = codec_predict(CMD_ENCODE, din, '0);
      return r.code_out;
   endfunction

   // invert a number of distinct random bits of a codeword
   function automatic logic [CODE_W-1:0] flip_bits(input logic [CODE_W-1:0] w, input int n);
      logic [CODE_W-1:0] mask;
      mask = '0;
      while ($countones(mask) < n) begin
         mask[$urandom_range(0, CODE_W - 1)] = 1'b1;
      end
      return w ^ mask;
   endfunction

   // drive one request transaction and record its expected result on acceptance
   task automatic send_item(input logic cmd, input logic [DATA_W-1:0] din,
                            input logic [CODE_W-1:0] cin);
      int      gap;
      rsp_type exp_rsp;
      gap = req_idle_on ? $urandom_range(0, STALL_MAX) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.command <= cmd;
      req_ch.data_in <= din;
      req_ch.code_in <= cin;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      exp_rsp = codec_predict(cmd, din, cin);
      expected_rsp_q.push_back(exp_rsp);
      if (cmd == CMD_ENCODE) begin
         encode_count++;
      end else begin
         status_count[exp_rsp.status]++;
      end
   endtask

   task automatic send_encode(input logic [DATA_W-1:0] din);
      send_item(CMD_ENCODE, din, {7'($urandom), 32'($urandom)});
   endtask

   task automatic send_decode(input logic [CODE_W-1:0] cin);
      send_item(CMD_DECODE, 32'($urandom), cin);
   endtask

   // random data word, with an edge pattern now and then
   function automatic logic [DATA_W-1:0] pick_data();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return DATA_W'(1) << $urandom_range(0, DATA_W - 1);
         3: return ~(DATA_W'(1) << $urandom_range(0, DATA_W - 1));
         default: return 32'($urandom);
      endcase
   endfunction

   // extremes of the data word through the encoder
   task automatic test_encode_edges();
      send_encode('0);
      send_encode('1);
      send_encode(32'h0000_0001);
      send_encode(32'h8000_0000);
      send_encode(32'h5555_5555);
      send_encode(32'hAAAA_AAAA);
   endtask

   // every decode outcome on a known codeword
   task automatic test_decode_cases();
      logic [CODE_W-1:0] cw;
      cw = clean_code(32'hC0DE_1234);
      send_decode(cw);
      // single error in a data position and in a check position
      send_decode(cw ^ (CODE_W'(1) << 2));
      send_decode(cw ^ (CODE_W'(1) << 7));
      // single error in the highest data position
      send_decode(cw ^ (CODE_W'(1) << (CODE_BITS - 1)));
      // overall parity bit alone
      send_decode(cw ^ (CODE_W'(1) << CODE_BITS));
      // double error
      send_decode(cw ^ (CODE_W'(1) << 2) ^ (CODE_W'(1) << 9));
      // three flips at positions 1, 6 and 32 give a syndrome past the codeword
      send_decode(cw ^ (CODE_W'(1) << 0) ^ (CODE_W'(1) << 5) ^ (CODE_W'(1) << 31));
      // all-zero and all-one received words
      send_decode('0);
      send_decode('1);
      send_decode(clean_code('1));
   endtask

   // encodes, and decodes of mostly well-formed codewords with up to three errors, some raw noise
   task automatic test_random_traffic();
      int                sel;
      logic [CODE_W-1:0] cw;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 100 == 0) begin
            req_idle_on = ($urandom_range(0, 3) != 0);
            rsp_idle_on = ($urandom_range(0, 3) != 0);
         end
         sel = $urandom_range(0, 99);
         cw  = clean_code(pick_data());
         if (sel < 35) begin
            send_encode(pick_data());
         end else if (sel < 55) begin
            send_decode(cw);
         end else if (sel < 75) begin
            send_decode(flip_bits(cw, 1));
         end else if (sel < 88) begin
            send_decode(flip_bits(cw, 2));
         end else if (sel < 95) begin
            send_decode(flip_bits(cw, 3));
         end else begin
            send_decode({7'($urandom), 32'($urandom)});
         end
      end
   endtask

   // receiver holds off while the sender keeps offering back to back
   task automatic test_backpressure();
      req_idle_on  = 1'b0;
      rsp_idle_on  = 1'b0;
      rsp_hold_req = 1'b1;
      for (int i = 0; i < BURST_ITEMS; i++) begin
         if ($urandom_range(0, 1) != 0) begin
            send_encode(32'($urandom));
         end else begin
            send_decode(flip_bits(clean_code(32'($urandom)), $urandom_range(0, 2)));
         end
      end
   endtask

   // stimulus sequence
   initial begin
      error_count   = 0;
      checked_count = 0;
      encode_count  = 0;
      status_count  = '{default: 0};
      req_idle_on   = 1'b1;
      rsp_idle_on   = 1'b1;
      rsp_hold_req  = 1'b0;
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.command = CMD_ENCODE;
      req_ch.data_in = '0;
      req_ch.code_in = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_encode_edges();
      test_decode_cases();
      test_random_traffic();
      test_backpressure();
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      test_random_traffic();

      req_ch.valid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("checked %0d results: %0d encodes; decodes clean %0d, corrected %0d,",
               checked_count, encode_count, status_count[STATUS_CLEAN],
               status_count[STATUS_CORRECTED]);
      $display("  double %0d, parity bit only %0d, syndrome out of range %0d",
               status_count[STATUS_DOUBLE], status_count[STATUS_PARITY],
               status_count[STATUS_RANGE]);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // result receiver with random stalls and one long hold-off on request
   initial begin
      int gap;
      rsp_ch.ready = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold_req) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold_req = 1'b0;
         end else begin
            gap = rsp_idle_on ? $urandom_range(0, STALL_MAX) : 0;
            if (gap > 0) begin
               rsp_ch.ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
      end
   end

   // compare each result transaction with the oldest expectation
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_rsp_q.size() == 0) begin
            $display("%0t: unexpected result code_out=%h data_out=%h syndrome=%h status=%0d",
                     $time, rsp_ch.code_out, rsp_ch.data_out, rsp_ch.syndrome,
                     rsp_ch.status);
            error_count++;
         end else begin
            exp_rsp = expected_rsp_q.pop_front();
            checked_count++;
            if (rsp_ch.code_out !== exp_rsp.code_out) begin
               $display("%0t: code_out expected %h actual %h",
                        $time, exp_rsp.code_out, rsp_ch.code_out);
               error_count++;
            end
            if (rsp_ch.data_out !== exp_rsp.data_out) begin
               $display("%0t: data_out expected %h actual %h",
                        $time, exp_rsp.data_out, rsp_ch.data_out);
               error_count++;
            end
            if (rsp_ch.syndrome !== exp_rsp.syndrome) begin
               $display("%0t: syndrome expected %0d actual %0d",
                        $time, exp_rsp.syndrome, rsp_ch.syndrome);
               error_count++;
            end
            if (rsp_ch.status !== exp_rsp.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, exp_rsp.status, rsp_ch.status);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles without any accepted transaction
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_MAX) begin
         $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
